FILE: rtl/octree_morton_neighbor_id_assert.svh
// Assertion macros for the port-level checker of the neighbor lookup block.
`ifndef OCTREE_MORTON_NEIGHBOR_ID_ASSERT_SVH
`define OCTREE_MORTON_NEIGHBOR_ID_ASSERT_SVH

// Generic clocked assertion with an active-high reset that disables it.
`define ONID_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion on the block clock and reset.
`define ONID_ASSERT(label, prop, msg) \
   `ONID_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

FILE: rtl/onid_pkg.sv
`default_nettype none

package onid_pkg;

   // Width of a node id.
   localparam int ID_BITS = 64;
   localparam int DIR_BITS = 5;

   // Level marker: binary 101 with its top bit at MARKER_TOP_OFFSET + LEVEL_STRIDE * level.
   localparam logic [ID_BITS-1:0] MARKER_BASE = 64'h0000_0000_0140_0000;
   localparam int MARKER_TOP_OFFSET = 24;
   localparam int LEVEL_STRIDE = 3;
   localparam int NUM_AXES = 3;

   // Cycles from an accepted transaction to its result strobe.
   localparam int PIPE_DEPTH = 3;

   // Input and result transactions.
   typedef struct packed {
      logic [ID_BITS-1:0]  node_id;
      logic [DIR_BITS-1:0] direction;
   } req_type;

   typedef struct packed {
      logic [ID_BITS-1:0] neighbor_id;
      logic               id_error;
   } rsp_type;

   // Move on one axis: increment, decrement or neither.
   typedef struct packed {
      logic inc;
      logic dec;
   } axis_move_type;

   typedef struct packed {
      axis_move_type z;
      axis_move_type y;
      axis_move_type x;
   } move_type;

   localparam axis_move_type MV_UP = 2'b10;
   localparam axis_move_type MV_DN = 2'b01;
   localparam axis_move_type MV_NO = 2'b00;

   // Direction codes: faces, then edges, then corners.
   typedef enum logic [DIR_BITS-1:0] {
      DIR_EAST                = 5'd0,
      DIR_WEST                = 5'd1,
      DIR_NORTH               = 5'd2,
      DIR_SOUTH               = 5'd3,
      DIR_TOP                 = 5'd4,
      DIR_BOTTOM              = 5'd5,
      DIR_BOTTOM_NORTH        = 5'd6,
      DIR_BOTTOM_SOUTH        = 5'd7,
      DIR_TOP_NORTH           = 5'd8,
      DIR_TOP_SOUTH           = 5'd9,
      DIR_BOTTOM_EAST         = 5'd10,
      DIR_BOTTOM_WEST         = 5'd11,
      DIR_TOP_EAST            = 5'd12,
      DIR_TOP_WEST            = 5'd13,
      DIR_NORTH_EAST          = 5'd14,
      DIR_NORTH_WEST          = 5'd15,
      DIR_SOUTH_EAST          = 5'd16,
      DIR_SOUTH_WEST          = 5'd17,
      DIR_EAST_NORTH_TOP      = 5'd18,
      DIR_EAST_NORTH_BOTTOM   = 5'd19,
      DIR_EAST_SOUTH_TOP      = 5'd20,
      DIR_EAST_SOUTH_BOTTOM   = 5'd21,
      DIR_WEST_NORTH_TOP      = 5'd22,
      DIR_WEST_NORTH_BOTTOM   = 5'd23,
      DIR_WEST_SOUTH_TOP      = 5'd24,
      DIR_WEST_SOUTH_BOTTOM   = 5'd25
   } dir_type;

   // Per-axis moves of a direction code, listed as {z, y, x}.
   // Codes without a direction move on no axis.
   function automatic move_type dir_move(input logic [DIR_BITS-1:0] dir);
      move_type mv;
      case (dir)
         DIR_EAST:              mv = {MV_NO, MV_NO, MV_UP};
         DIR_WEST:              mv = {MV_NO, MV_NO, MV_DN};
         DIR_NORTH:             mv = {MV_NO, MV_UP, MV_NO};
         DIR_SOUTH:             mv = {MV_NO, MV_DN, MV_NO};
         DIR_TOP:               mv = {MV_UP, MV_NO, MV_NO};
         DIR_BOTTOM:            mv = {MV_DN, MV_NO, MV_NO};
         DIR_BOTTOM_NORTH:      mv = {MV_DN, MV_UP, MV_NO};
         DIR_BOTTOM_SOUTH:      mv = {MV_DN, MV_DN, MV_NO};
         DIR_TOP_NORTH:         mv = {MV_UP, MV_UP, MV_NO};
         DIR_TOP_SOUTH:         mv = {MV_UP, MV_DN, MV_NO};
         DIR_BOTTOM_EAST:       mv = {MV_DN, MV_NO, MV_UP};
         DIR_BOTTOM_WEST:       mv = {MV_DN, MV_NO, MV_DN};
         DIR_TOP_EAST:          mv = {MV_UP, MV_NO, MV_UP};
         DIR_TOP_WEST:          mv = {MV_UP, MV_NO, MV_DN};
         DIR_NORTH_EAST:        mv = {MV_NO, MV_UP, MV_UP};
         DIR_NORTH_WEST:        mv = {MV_NO, MV_UP, MV_DN};
         DIR_SOUTH_EAST:        mv = {MV_NO, MV_DN, MV_UP};
         DIR_SOUTH_WEST:        mv = {MV_NO, MV_DN, MV_DN};
         DIR_EAST_NORTH_TOP:    mv = {MV_UP, MV_UP, MV_UP};
         DIR_EAST_NORTH_BOTTOM: mv = {MV_DN, MV_UP, MV_UP};
         DIR_EAST_SOUTH_TOP:    mv = {MV_UP, MV_DN, MV_UP};
         DIR_EAST_SOUTH_BOTTOM: mv = {MV_DN, MV_DN, MV_UP};
         DIR_WEST_NORTH_TOP:    mv = {MV_UP, MV_UP, MV_DN};
         DIR_WEST_NORTH_BOTTOM: mv = {MV_DN, MV_UP, MV_DN};
         DIR_WEST_SOUTH_TOP:    mv = {MV_UP, MV_DN, MV_DN};
         DIR_WEST_SOUTH_BOTTOM: mv = {MV_DN, MV_DN, MV_DN};
         default:               mv = {MV_NO, MV_NO, MV_NO};
      endcase
      return mv;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/onid_axis_step.sv
`default_nettype none

// Gathers one interleaved coordinate out of the unmarked id and steps it by one when a move is given.
module onid_axis_step #(
   parameter int AXIS_BITS = 20,
   parameter int AXIS_SEL = 0
) (
   input  wire logic [onid_pkg::ID_BITS-1:0] work,
   input  wire onid_pkg::axis_move_type      move,
   output logic [AXIS_BITS-1:0]              coord_next
);
   import onid_pkg::*;

   logic [AXIS_BITS-1:0] coord;

   // Every third bit of the id belongs to this axis.
   always_comb begin
      for (int i = 0; i < AXIS_BITS; i++) begin
         coord[i] = work[NUM_AXES * i + AXIS_SEL];
      end
   end

   // The carry or borrow out of the top coordinate bit is dropped.
   always_comb begin
      if (move.inc) begin
         coord_next = coord + AXIS_BITS'(1);
      end else if (move.dec) begin
         coord_next = coord - AXIS_BITS'(1);
      end else begin
         coord_next = coord;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/octree_morton_neighbor_id.sv
// Octree neighbor lookup on Morton-coded node ids.
// Throughput: one transaction per cycle while busy is low; the three-stage pipeline
// never stalls. Stages: marker search and removal, coordinate step, marker restore.
// Reset clears all valid bits; busy stays high for the cycle after reset.
`default_nettype none

module octree_morton_neighbor_id #(
   parameter int MAX_LEVELS = 14,
   parameter int AXIS_BITS = 20
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire onid_pkg::req_type req_data,
   output logic                   busy,
   output logic                   rsp_valid,
   output onid_pkg::rsp_type      rsp_data
);
   import onid_pkg::*;

   logic                    accept;
   logic [MAX_LEVELS-1:0]   level_hit;
   logic [ID_BITS-1:0]      marker_in;
   logic                    busy_ff;

   logic                    s1_valid_ff;
   logic [ID_BITS-1:0]      s1_work_ff;
   logic [ID_BITS-1:0]      s1_marker_ff;
   logic                    s1_error_ff;
   move_type                s1_move_ff;

   logic [AXIS_BITS-1:0]    coord_next [NUM_AXES];
   logic [ID_BITS-1:0]      s2_work_in;
   logic                    s2_valid_ff;
   logic [ID_BITS-1:0]      s2_work_ff;
   logic [ID_BITS-1:0]      s2_marker_ff;
   logic                    s2_error_ff;

   logic [ID_BITS-1:0]      neighbor_sum;
   rsp_type                 rsp_data_in;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;

   // The pipeline never stalls, so the block is busy only around reset.
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy = busy_ff;
   assign accept = start && !busy_ff;

   // Marker search: the top marker bit must be the highest set bit, followed by 0 then 1.
   for (genvar lvl = 0; lvl < MAX_LEVELS; lvl++) begin : g_level
      localparam int TOP = MARKER_TOP_OFFSET + LEVEL_STRIDE * lvl;
      assign level_hit[lvl] = ((req_data.node_id >> TOP) == ID_BITS'(1))
                              && !req_data.node_id[TOP-1] && req_data.node_id[TOP-2];
   end

   // At most one level can match, so the markers are simply merged.
   always_comb begin
      marker_in = '0;
      for (int lvl = 0; lvl < MAX_LEVELS; lvl++) begin
         if (level_hit[lvl]) begin
            marker_in = marker_in | (MARKER_BASE << (LEVEL_STRIDE * lvl));
         end
      end
   end

   // Stage one: valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   // Stage one: unmarked id, marker, error flag and decoded moves.
   always_ff @(posedge clock) begin
      s1_work_ff   <= req_data.node_id & ~marker_in;
      s1_marker_ff <= marker_in;
      s1_error_ff  <= ~|level_hit;
      s1_move_ff   <= dir_move(req_data.direction);
   end

   // Coordinate steppers, one for each axis.
   onid_axis_step #(.AXIS_BITS(AXIS_BITS), .AXIS_SEL(0)) u_step_x (
      .work       (s1_work_ff),
      .move       (s1_move_ff.x),
      .coord_next (coord_next[0])
   );

   onid_axis_step #(.AXIS_BITS(AXIS_BITS), .AXIS_SEL(1)) u_step_y (
      .work       (s1_work_ff),
      .move       (s1_move_ff.y),
      .coord_next (coord_next[1])
   );

   onid_axis_step #(.AXIS_BITS(AXIS_BITS), .AXIS_SEL(2)) u_step_z (
      .work       (s1_work_ff),
      .move       (s1_move_ff.z),
      .coord_next (coord_next[2])
   );

   // Scatter the stepped coordinates back; bits outside them are kept.
   always_comb begin
      s2_work_in = s1_work_ff;
      for (int a = 0; a < NUM_AXES; a++) begin
         for (int i = 0; i < AXIS_BITS; i++) begin
            s2_work_in[NUM_AXES * i + a] = coord_next[a][i];
         end
      end
   end

   // Stage two registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_work_ff   <= s2_work_in;
      s2_marker_ff <= s1_marker_ff;
      s2_error_ff  <= s1_error_ff;
   end

   // The marker goes back by a wrapping add, since a step may have carried into its bits.
   assign neighbor_sum = s2_work_ff + s2_marker_ff;

   always_comb begin
      if (s2_error_ff) begin
         rsp_data_in.neighbor_id = '0;
         rsp_data_in.id_error    = 1'b1;
      end else begin
         rsp_data_in.neighbor_id = neighbor_sum;
         rsp_data_in.id_error    = 1'b0;
      end
   end

   // Output register: the strobe lasts one cycle per transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/onid_checker.sv
`default_nettype none

`include "octree_morton_neighbor_id_assert.svh"

// Port-level checks of the neighbor lookup block.
module onid_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire onid_pkg::req_type req_data,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire onid_pkg::rsp_type rsp_data
);
   import onid_pkg::*;

   // Every accepted transaction produces its strobe after the fixed latency.
   `ONID_ASSERT(a_rsp_follows_req, (start && !busy) |-> ##PIPE_DEPTH rsp_valid, "result missing")

   // No strobe appears without a transaction accepted at the fixed latency before it.
   `ONID_ASSERT(a_rsp_has_req, rsp_valid |-> $past(start && !busy, PIPE_DEPTH), "spurious result")

   // An error result carries a zero neighbor id.
   `ONID_ASSERT(a_error_zero, (rsp_valid && rsp_data.id_error) |-> (rsp_data.neighbor_id == '0), "error id not zero")

   // An id with no set bit at all, seen at acceptance, gives an error result.
   `ONID_ASSERT(a_zero_id_error, (rsp_valid && $past(req_data.node_id == '0, PIPE_DEPTH)) |-> rsp_data.id_error, "zero id not flagged")

endmodule

bind octree_morton_neighbor_id onid_checker u_onid_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .req_data  (req_data),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: verif/octree_morton_neighbor_id_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the neighbor lookup, predicts each result and compares it.
module octree_morton_neighbor_id_checker
   import onid_pkg::*;
#(
   parameter int MAX_LEVELS = 14,
   parameter int AXIS_BITS = 20
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic busy,
   input  req_type   req_data,
   input  wire logic rsp_valid,
   input  rsp_type   rsp_data,
   output int        failures,
   output int        outstanding
);

   // Per-axis step codes, packed as {z, y, x}.
   localparam logic [1:0] AX_HOLD = 2'd0;
   localparam logic [1:0] AX_INC  = 2'd1;
   localparam logic [1:0] AX_DEC  = 2'd2;

   rsp_type neighbor_q[$];
   int      fail_count;
   int      pending_count;

   // Steps that a direction code makes on each axis; unused codes make none.
   function automatic logic [5:0] axis_steps(input logic [DIR_BITS-1:0] dir);
      logic [5:0] steps;
      case (dir)
         DIR_EAST:              steps = {AX_HOLD, AX_HOLD, AX_INC};
         DIR_WEST:              steps = {AX_HOLD, AX_HOLD, AX_DEC};
         DIR_NORTH:             steps = {AX_HOLD, AX_INC, AX_HOLD};
         DIR_SOUTH:             steps = {AX_HOLD, AX_DEC, AX_HOLD};
         DIR_TOP:               steps = {AX_INC, AX_HOLD, AX_HOLD};
         DIR_BOTTOM:            steps = {AX_DEC, AX_HOLD, AX_HOLD};
         DIR_BOTTOM_NORTH:      steps = {AX_DEC, AX_INC, AX_HOLD};
         DIR_BOTTOM_SOUTH:      steps = {AX_DEC, AX_DEC, AX_HOLD};
         DIR_TOP_NORTH:         steps = {AX_INC, AX_INC, AX_HOLD};
         DIR_TOP_SOUTH:         steps = {AX_INC, AX_DEC, AX_HOLD};
         DIR_BOTTOM_EAST:       steps = {AX_DEC, AX_HOLD, AX_INC};
         DIR_BOTTOM_WEST:       steps = {AX_DEC, AX_HOLD, AX_DEC};
         DIR_TOP_EAST:          steps = {AX_INC, AX_HOLD, AX_INC};
         DIR_TOP_WEST:          steps = {AX_INC, AX_HOLD, AX_DEC};
         DIR_NORTH_EAST:        steps = {AX_HOLD, AX_INC, AX_INC};
         DIR_NORTH_WEST:        steps = {AX_HOLD, AX_INC, AX_DEC};
         DIR_SOUTH_EAST:        steps = {AX_HOLD, AX_DEC, AX_INC};
         DIR_SOUTH_WEST:        steps = {AX_HOLD, AX_DEC, AX_DEC};
         DIR_EAST_NORTH_TOP:    steps = {AX_INC, AX_INC, AX_INC};
         DIR_EAST_NORTH_BOTTOM: steps = {AX_DEC, AX_INC, AX_INC};
         DIR_EAST_SOUTH_TOP:    steps = {AX_INC, AX_DEC, AX_INC};
         DIR_EAST_SOUTH_BOTTOM: steps = {AX_DEC, AX_DEC, AX_INC};
         DIR_WEST_NORTH_TOP:    steps = {AX_INC, AX_INC, AX_DEC};
         DIR_WEST_NORTH_BOTTOM: steps = {AX_DEC, AX_INC, AX_DEC};
         DIR_WEST_SOUTH_TOP:    steps = {AX_INC, AX_DEC, AX_DEC};
         DIR_WEST_SOUTH_BOTTOM: steps = {AX_DEC, AX_DEC, AX_DEC};
         default:               steps = {AX_HOLD, AX_HOLD, AX_HOLD};
      endcase
      return steps;
   endfunction

   // Computes the neighbor id of one lookup.
   function automatic rsp_type neighbor_of(input req_type lookup);
      logic [ID_BITS-1:0] id;
      logic [ID_BITS-1:0] marker;
      logic [ID_BITS-1:0] work;
      logic [ID_BITS-1:0] mask;
      logic [ID_BITS-1:0] part;
      logic [5:0]         steps;
      logic               found;
      int                 lvl;
      int                 top;
      int                 axis;
      int                 bit_idx;
      rsp_type            result;
      id = lookup.node_id;
      marker = '0;
      found = 1'b0;

      // The marker's top bit must be the highest set bit, followed by 0 then 1.
      for (lvl = 0; lvl < MAX_LEVELS; lvl++) begin
         top = MARKER_TOP_OFFSET + LEVEL_STRIDE * lvl;
         if (!found && top <= ID_BITS - 1 && (id >> top) == 64'd1 &&
             !id[top-1] && id[top-2]) begin
            found = 1'b1;
            marker = MARKER_BASE << (LEVEL_STRIDE * lvl);
         end
      end
      if (!found) begin
         result.neighbor_id = '0;
         result.id_error = 1'b1;
         return result;
      end

      // Step each interleaved coordinate; carries out of the top bit are dropped.
      work = id - marker;
      steps = axis_steps(lookup.direction);
      for (axis = 0; axis < NUM_AXES; axis++) begin
         mask = '0;
         for (bit_idx = 0; bit_idx < AXIS_BITS; bit_idx++) begin
            if (NUM_AXES * bit_idx + axis < ID_BITS) begin
               mask[NUM_AXES * bit_idx + axis] = 1'b1;
            end
         end
         part = work & mask;
         case (steps[2*axis +: 2])
            AX_INC:  part = ((part | ~mask) + 64'd1) & mask;
            AX_DEC:  part = (part - 64'd1) & mask;
            default: part = part;
         endcase
         work = (work & ~mask) | part;
      end
      result.neighbor_id = work + marker;
      result.id_error = 1'b0;
      return result;
   endfunction

   initial begin
      fail_count = 0;
      pending_count = 0;
      failures = 0;
      outstanding = 0;
   end

   // Record each accepted lookup and check each result against the oldest expectation.
   always @(posedge clock) begin
      rsp_type expected;
      if (!reset) begin
         if (start && !busy) begin
            neighbor_q.push_back(neighbor_of(req_data));
         end
         if (rsp_valid) begin
            if (neighbor_q.size() == 0) begin
               $error("rsp_valid with no transaction outstanding: neighbor_id %h, id_error %b",
                      rsp_data.neighbor_id, rsp_data.id_error);
               fail_count++;
            end else begin
               expected = neighbor_q.pop_front();
               if (rsp_data.neighbor_id !== expected.neighbor_id) begin
                  $error("neighbor_id: expected %h, actual %h",
                         expected.neighbor_id, rsp_data.neighbor_id);
                  fail_count++;
               end
               if (rsp_data.id_error !== expected.id_error) begin
                  $error("id_error: expected %b, actual %b",
                         expected.id_error, rsp_data.id_error);
                  fail_count++;
               end
            end
         end
         pending_count = neighbor_q.size();
      end
      failures <= fail_count;
      outstanding <= pending_count;
   end

endmodule

FILE: verif/octree_morton_neighbor_id_test.sv
`timescale 1ns / 100ps

// Drives lookups into the neighbor block and gives the verdict from the checker's count.
module octree_morton_neighbor_id_test;
   import onid_pkg::*;

   localparam int MAX_LEVELS = 14;
   localparam int AXIS_BITS = 20;
   localparam int RESET_CYCLES = 11;
   localparam int ITEMS_PER_PHASE = 620;
   localparam int NUM_PHASES = 3;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [DIR_BITS-1:0] DIR_UNUSED_FIRST = 5'd26;
   localparam logic [DIR_BITS-1:0] DIR_UNUSED_LAST  = 5'd31;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      failures;
   int      outstanding;
   int      cycle_count;

   octree_morton_neighbor_id #(
      .MAX_LEVELS(MAX_LEVELS),
      .AXIS_BITS(AXIS_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_data(req_data),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   octree_morton_neighbor_id_checker #(
      .MAX_LEVELS(MAX_LEVELS),
      .AXIS_BITS(AXIS_BITS)
   ) neighbor_check (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .failures(failures),
      .outstanding(outstanding)
   );

   // Clock with a 10 ns period.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [ID_BITS-1:0] rand_id();
      return {$urandom, $urandom};
   endfunction

   // Valid node id on a level, with the bits below the marker taken from fill.
   function automatic logic [ID_BITS-1:0] node_at(input int level,
                                                 input logic [ID_BITS-1:0] fill);
      int top;
      top = MARKER_TOP_OFFSET + LEVEL_STRIDE * level;
      return (MARKER_BASE << (LEVEL_STRIDE * level)) | (fill & ((64'd1 << (top - 2)) - 64'd1));
   endfunction

   // Mostly well-formed ids with random or extreme coordinates, the rest broken markers.
   function automatic req_type random_lookup();
      req_type lookup;
      int      level;
      int      top;
      logic [ID_BITS-1:0] fill;
      level = $urandom_range(0, MAX_LEVELS - 1);
      top = MARKER_TOP_OFFSET + LEVEL_STRIDE * level;
      case ($urandom_range(0, 9))
         0:       fill = '1;
         1:       fill = '0;
         2:       fill = rand_id() & rand_id();
         3:       fill = rand_id() | rand_id();
         default: fill = rand_id();
      endcase
      lookup.node_id = node_at(level, fill);
      if ($urandom_range(0, 99) >= 85) begin
         case ($urandom_range(0, 4))
            0: lookup.node_id = rand_id();
            1: lookup.node_id = lookup.node_id | (64'd1 << (top - 1));
            2: lookup.node_id = lookup.node_id & ~(64'd1 << (top - 2));
            3: lookup.node_id = rand_id() >> $urandom_range(0, ID_BITS - 1);
            default: lookup.node_id = lookup.node_id << $urandom_range(1, 2);
         endcase
      end
      if ($urandom_range(0, 9) == 0) begin
         lookup.direction = DIR_BITS'($urandom_range(DIR_UNUSED_FIRST, DIR_UNUSED_LAST));
      end else begin
         lookup.direction = DIR_BITS'($urandom_range(DIR_EAST, DIR_WEST_SOUTH_BOTTOM));
      end
      return lookup;
   endfunction

   // Present one transaction, after an optional idle gap, and hold it until accepted.
   task automatic send_lookup(input req_type lookup, input int idle_share);
      if ($urandom_range(1, 100) <= idle_share) begin
         start <= 1'b0;
         req_data <= random_lookup();
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= lookup;
      do @(posedge clock); while (busy);
   endtask

   // Stop sending until every outstanding transaction has returned.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Run-length guard.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("octree_morton_neighbor_id regression: fail");
      $finish;
   end

   initial begin
      req_type lookup;
      logic [ID_BITS-1:0] corner_ids [4];
      int phase;
      int idle_share;
      int n;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Every direction, each on one of four ids: lowest or highest level, all-zero or all-one coordinates.
      corner_ids[0] = node_at(0, '0);
      corner_ids[1] = node_at(MAX_LEVELS - 1, '1);
      corner_ids[2] = node_at(0, '1);
      corner_ids[3] = node_at(MAX_LEVELS - 1, '0);
      for (n = DIR_EAST; n <= DIR_WEST_SOUTH_BOTTOM; n++) begin
         lookup.node_id = corner_ids[n[1:0]];
         lookup.direction = DIR_BITS'(n);
         send_lookup(lookup, 0);
      end

      // Ids without a valid marker, and an unused direction code.
      lookup.node_id = '0;
      lookup.direction = DIR_EAST;
      send_lookup(lookup, 0);
      lookup.node_id = '1;
      lookup.direction = DIR_WEST;
      send_lookup(lookup, 0);
      lookup.node_id = node_at(5, rand_id()) | (64'd1 << (MARKER_TOP_OFFSET + 14));
      lookup.direction = DIR_TOP;
      send_lookup(lookup, 0);
      lookup.node_id = node_at(6, rand_id());
      lookup.direction = DIR_UNUSED_LAST;
      send_lookup(lookup, 0);
      drain();

      // Random phases: back to back, heavy idling, light idling.
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0:       idle_share = 0;
            1:       idle_share = 59;
            default: idle_share = 7;
         endcase
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_lookup(random_lookup(), idle_share);
         end
         drain();
      end

      repeat (PIPE_DEPTH + 4) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("octree_morton_neighbor_id regression: pass");
      end else begin
         if (outstanding != 0) begin
            $error("%0d transactions never returned a result", outstanding);
         end
         $display("octree_morton_neighbor_id regression: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/onid_pkg.sv
rtl/onid_axis_step.sv
rtl/octree_morton_neighbor_id.sv
rtl/onid_checker.sv
verif/octree_morton_neighbor_id_checker.sv
verif/octree_morton_neighbor_id_test.sv
